// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GVL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gvl check failed");

// next-cycle implication, disabled while in reset
`define GVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gvl check failed");

`endif

// ===== hw/rtl/gvl_pkg.sv =====
package gvl_pkg;

    // payload widths
    localparam int OP_W     = 2;
    localparam int CIDX_W   = 12;
    localparam int VEL_W    = 32;
    localparam int LONG_W   = 29;
    localparam int LAT_W    = 28;
    localparam int DIM_W    = 7;
    localparam int SCALE_W  = 48;
    localparam int OFFS_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // shared unit widths
    localparam int MUL_A_W  = 29;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 80;
    localparam int FRAC_W   = 40;
    localparam int SCALE_LO_W = 24;

    // smoothing accumulator width
    localparam int SACC_W   = 36;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_SMOOTH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd5;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH
    } acc_op_t;

    typedef struct packed {
        logic                        mul_en;
        logic signed [MUL_A_W-1:0]   mul_a;
        logic signed [MUL_B_W-1:0]   mul_b;
        acc_op_t                     acc_op;
        logic signed [OFFS_W-1:0]    load_val;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XLO,
        ST_XHI,
        ST_XSUM,
        ST_YLO,
        ST_YHI,
        ST_YSUM,
        ST_YCHK,
        ST_IDX,
        ST_ADDR,
        ST_READ,
        ST_DRAIN,
        ST_FIN
    } state_t;

endpackage

// ===== hw/rtl/gvl_if.sv =====
interface gvl_req_if
    import gvl_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [CIDX_W-1:0]         cell_index;
    logic signed [VEL_W-1:0]   write_u;
    logic signed [VEL_W-1:0]   write_v;
    logic signed [LONG_W-1:0]  point_long;
    logic signed [LAT_W-1:0]   point_lat;

    modport source (
        output valid, operation, cell_index, write_u, write_v, point_long, point_lat,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_index, write_u, write_v, point_long, point_lat,
        output ready
    );
endinterface

interface gvl_rsp_if
    import gvl_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VEL_W-1:0]   vel_u;
    logic signed [VEL_W-1:0]   vel_v;
    logic                      in_grid;
    logic                      was_smoothed;

    modport source (
        output valid, vel_u, vel_v, in_grid, was_smoothed,
        input  ready
    );
    modport sink (
        input  valid, vel_u, vel_v, in_grid, was_smoothed,
        output ready
    );
endinterface

interface gvl_cfg_if
    import gvl_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_W-1:0]      index;
    logic [CFG_DAT_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== hw/rtl/gvl_ram.sv =====
module gvl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/gvl_mac.sv =====
module gvl_mac
    import gvl_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int LIM_W = 7
) (
    input  logic                      clk,
    input  mac_ctrl_t                 ctrl,
    input  logic [LIM_W-1:0]          lim,
    output logic signed [PROD_W-1:0]  prod,
    output logic                      coord_ok,
    output logic [IDX_W-1:0]          coord_idx
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic [ACC_W-FRAC_W-1:0]  int_part;
    logic                     neg;
    logic                     neg_ok;
    logic                     pos_ok;
    logic [IDX_W-1:0]         idx_val;

    // registered product; accumulator holds, loads an offset, or adds the product plain or shifted
    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD:   acc_next = {{(ACC_W-OFFS_W){ctrl.load_val[OFFS_W-1]}}, ctrl.load_val};
            ACC_ADD:    acc_next = acc_reg
                                 + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            ACC_ADD_SH: acc_next = acc_reg
                                 + {{(ACC_W-PROD_W-SCALE_LO_W){prod_reg[PROD_W-1]}},
                                    prod_reg, {SCALE_LO_W{1'b0}}};
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= ctrl.mul_a * ctrl.mul_b;
        end
        acc_reg <= acc_next;
    end

    // truncate toward zero, then range check against the limit
    always_comb
    begin
        int_part = acc_reg[ACC_W-1:FRAC_W];
        neg      = acc_reg[ACC_W-1];
        neg_ok   = (&int_part) && (acc_reg[FRAC_W-1:0] != '0);
        pos_ok   = (int_part[ACC_W-FRAC_W-1:IDX_W] == '0);
        idx_val  = neg ? '0 : int_part[IDX_W-1:0];
        coord_ok = (neg ? neg_ok : pos_ok) && (LIM_W'(idx_val) < lim);
        coord_idx = idx_val;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/gvl_smooth.sv =====
module gvl_smooth
    import gvl_pkg::*;
(
    input  logic                     clk,
    input  logic                     data_vld,
    input  logic                     first,
    input  logic [2*VEL_W-1:0]       rd_data,
    output logic signed [VEL_W-1:0]  ctr_u,
    output logic signed [VEL_W-1:0]  ctr_v,
    output logic signed [VEL_W-1:0]  avg_u,
    output logic signed [VEL_W-1:0]  avg_v
);

    logic signed [SACC_W-1:0] acc_u_reg;
    logic signed [SACC_W-1:0] acc_v_reg;
    logic signed [VEL_W-1:0]  ctr_u_reg;
    logic signed [VEL_W-1:0]  ctr_v_reg;
    logic [VEL_W-1:0]         du;
    logic [VEL_W-1:0]         dv;

    assign du = rd_data[VEL_W-1:0];
    assign dv = rd_data[2*VEL_W-1:VEL_W];

    // centre seeds 4*c + 4 (rounding), neighbours add in
    always_ff @(posedge clk)
    begin
        if (data_vld)
        begin
            if (first)
            begin
                ctr_u_reg <= du;
                ctr_v_reg <= dv;
                acc_u_reg <= {{(SACC_W-VEL_W-2){du[VEL_W-1]}}, du, 2'b00} + SACC_W'(4);
                acc_v_reg <= {{(SACC_W-VEL_W-2){dv[VEL_W-1]}}, dv, 2'b00} + SACC_W'(4);
            end
            else
            begin
                acc_u_reg <= acc_u_reg + {{(SACC_W-VEL_W){du[VEL_W-1]}}, du};
                acc_v_reg <= acc_v_reg + {{(SACC_W-VEL_W){dv[VEL_W-1]}}, dv};
            end
        end
    end

    function automatic logic [VEL_W-1:0] sat_div8(input logic [SACC_W-1:0] t);
        logic [SACC_W-4:0] q;
        q = t[SACC_W-1:3];
        if (q[SACC_W-4] != q[SACC_W-5])
        begin
            return q[SACC_W-4] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end
        return q[VEL_W-1:0];
    endfunction

    assign ctr_u = ctr_u_reg;
    assign ctr_v = ctr_v_reg;
    assign avg_u = sat_div8(acc_u_reg);
    assign avg_v = sat_div8(acc_v_reg);

endmodule

// ===== hw/rtl/grid_velocity_lookup_smooth_core.sv =====
// write beat: stored in the accept cycle, ready stays high, no result
// query beat: off the grid the result follows the column and row passes, a plain lookup
// adds the index multiply and the centre read, a smoothed one four neighbour reads;
// ready returns once the result is registered; the time goes to six passes of the shared
// multiply-accumulate unit, one index multiply and up to five reads of the cell memory
// rst_n clears control and config registers; cell memory holds garbage until written
module grid_velocity_lookup_smooth_core
    import gvl_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    gvl_req_if.sink       req,
    gvl_rsp_if.source     rsp,
    gvl_cfg_if.sink       cfg
);

    // grid geometry
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RLW   = $clog2(MAX_ROWS + 1);
    localparam int CLW   = $clog2(MAX_COLS + 1);
    localparam int IDX_W = (RIW > CIW) ? RIW : CIW;
    localparam int LIM_W = (RLW > CLW) ? RLW : CLW;

    // config registers
    logic [DIM_W-1:0]          num_rows_reg;
    logic [DIM_W-1:0]          num_cols_reg;
    logic signed [SCALE_W-1:0] x_scale_reg;
    logic signed [OFFS_W-1:0]  x_offset_reg;
    logic signed [SCALE_W-1:0] y_scale_reg;
    logic signed [OFFS_W-1:0]  y_offset_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // captured query
    logic [OP_W-1:0]           op_reg;
    logic signed [LONG_W-1:0]  long_reg;
    logic signed [LAT_W-1:0]   lat_reg;

    // lookup working registers
    logic [CIW-1:0]            col_reg;
    logic [RIW-1:0]            row_reg;
    logic                      x_ok_reg;
    logic                      inside_reg;
    logic                      smooth_reg;
    logic [AW-1:0]             base_reg;
    logic [2:0]                rd_k_reg;
    logic                      rd_vld_reg;
    logic                      rd_first_reg;

    // result register
    logic                      rsp_valid_reg;
    logic signed [VEL_W-1:0]   vel_u_reg;
    logic signed [VEL_W-1:0]   vel_v_reg;
    logic                      in_grid_reg;
    logic                      smoothed_reg;

    // effective grid size, clipped to the store
    logic [RLW-1:0]            rows_eff;
    logic [CLW-1:0]            cols_eff;

    // shared unit hookup
    mac_ctrl_t                 mac_ctrl;
    logic [LIM_W-1:0]          mac_lim;
    logic signed [PROD_W-1:0]  mac_prod;
    logic                      coord_ok;
    logic [IDX_W-1:0]          coord_idx;

    // memory hookup
    logic                      ram_wr_en;
    logic                      ram_rd_en;
    logic [AW-1:0]             ram_rd_addr;
    logic [2*VEL_W-1:0]        ram_rd_data;

    // smoothing outputs
    logic signed [VEL_W-1:0]   ctr_u;
    logic signed [VEL_W-1:0]   ctr_v;
    logic signed [VEL_W-1:0]   avg_u;
    logic signed [VEL_W-1:0]   avg_v;

    logic                      req_beat;
    logic                      rd_last;
    logic                      smooth_cond;
    logic                      out_free;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_beat   = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !rsp_valid_reg || rsp.ready;

    // oversized grid settings clip to the store dimensions
    always_comb
    begin
        if (32'(num_rows_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = RLW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RLW'(num_rows_reg);
        end
        if (32'(num_cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = CLW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CLW'(num_cols_reg);
        end
    end

    // config writes, only while idle by contract
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= '0;
            num_cols_reg <= '0;
            x_scale_reg  <= '0;
            x_offset_reg <= '0;
            y_scale_reg  <= '0;
            y_offset_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_NUM_ROWS: num_rows_reg <= cfg.data[DIM_W-1:0];
                REG_NUM_COLS: num_cols_reg <= cfg.data[DIM_W-1:0];
                REG_X_SCALE:  x_scale_reg  <= cfg.data[SCALE_W-1:0];
                REG_X_OFFSET: x_offset_reg <= cfg.data;
                REG_Y_SCALE:  y_scale_reg  <= cfg.data[SCALE_W-1:0];
                REG_Y_OFFSET: y_offset_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // last read slot: centre only, or centre plus four neighbours
    assign rd_last = smooth_reg ? (rd_k_reg == 3'd4) : (rd_k_reg == 3'd0);

    // interior test for smoothing, uses the final row and column
    assign smooth_cond = (op_reg == OP_SMOOTH)
                      && (col_reg != '0) && ((CLW'(col_reg) + CLW'(1)) < cols_eff)
                      && (row_reg != '0) && ((RLW'(row_reg) + RLW'(1)) < rows_eff);

    // next state and shared unit control
    always_comb
    begin
        state_next        = state_reg;
        mac_ctrl.mul_en   = 1'b0;
        mac_ctrl.mul_a    = '0;
        mac_ctrl.mul_b    = '0;
        mac_ctrl.acc_op   = ACC_HOLD;
        mac_ctrl.load_val = '0;
        mac_lim           = LIM_W'(rows_eff);
        ram_rd_en         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat && (req.operation inside {OP_PLAIN, OP_SMOOTH}))
                begin
                    state_next = ST_XLO;
                end
            end
            // column: offset + long * scale, low then high scale half
            ST_XLO:
            begin
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.mul_a    = long_reg;
                mac_ctrl.mul_b    = {1'b0, x_scale_reg[SCALE_LO_W-1:0]};
                mac_ctrl.acc_op   = ACC_LOAD;
                mac_ctrl.load_val = x_offset_reg;
                state_next        = ST_XHI;
            end
            ST_XHI:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.mul_a  = long_reg;
                mac_ctrl.mul_b  = {x_scale_reg[SCALE_W-1], x_scale_reg[SCALE_W-1:SCALE_LO_W]};
                mac_ctrl.acc_op = ACC_ADD;
                state_next      = ST_XSUM;
            end
            ST_XSUM:
            begin
                mac_ctrl.acc_op = ACC_ADD_SH;
                state_next      = ST_YLO;
            end
            // row: column result is checked while the row pass starts
            ST_YLO:
            begin
                mac_lim           = LIM_W'(cols_eff);
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.mul_a    = {lat_reg[LAT_W-1], lat_reg};
                mac_ctrl.mul_b    = {1'b0, y_scale_reg[SCALE_LO_W-1:0]};
                mac_ctrl.acc_op   = ACC_LOAD;
                mac_ctrl.load_val = y_offset_reg;
                state_next        = ST_YHI;
            end
            ST_YHI:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.mul_a  = {lat_reg[LAT_W-1], lat_reg};
                mac_ctrl.mul_b  = {y_scale_reg[SCALE_W-1], y_scale_reg[SCALE_W-1:SCALE_LO_W]};
                mac_ctrl.acc_op = ACC_ADD;
                state_next      = ST_YSUM;
            end
            ST_YSUM:
            begin
                mac_ctrl.acc_op = ACC_ADD_SH;
                state_next      = ST_YCHK;
            end
            ST_YCHK:
            begin
                if (x_ok_reg && coord_ok)
                begin
                    state_next = ST_IDX;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            // row * cols through the same multiplier
            ST_IDX:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.mul_a  = MUL_A_W'(row_reg);
                mac_ctrl.mul_b  = MUL_B_W'(cols_eff);
                state_next      = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_rd_en = 1'b1;
                if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read address: centre, then south, north, west, east
    always_comb
    begin
        case (rd_k_reg)
            3'd0:    ram_rd_addr = base_reg;
            3'd1:    ram_rd_addr = base_reg + AW'(cols_eff);
            3'd2:    ram_rd_addr = base_reg - AW'(cols_eff);
            3'd3:    ram_rd_addr = base_reg - AW'(1);
            3'd4:    ram_rd_addr = base_reg + AW'(1);
            default: ram_rd_addr = base_reg;
        endcase
    end

    // write beats go straight to the store; indexes past the store are dropped
    assign ram_wr_en = req_beat && (req.operation == OP_WRITE)
                    && (32'(req.cell_index) < 32'(DEPTH));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= ram_rd_en;
            if (state_reg == ST_FIN && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            op_reg   <= req.operation;
            long_reg <= req.point_long;
            lat_reg  <= req.point_lat;
        end
        if (state_reg == ST_YLO)
        begin
            x_ok_reg <= coord_ok;
            col_reg  <= CIW'(coord_idx);
        end
        if (state_reg == ST_YCHK)
        begin
            inside_reg <= x_ok_reg && coord_ok;
            row_reg    <= RIW'(coord_idx);
        end
        if (state_reg == ST_ADDR)
        begin
            base_reg   <= AW'(mac_prod) + AW'(col_reg);
            smooth_reg <= smooth_cond;
            rd_k_reg   <= 3'd0;
        end
        else if (state_reg == ST_READ)
        begin
            rd_k_reg <= rd_k_reg + 3'd1;
        end
        rd_first_reg <= (state_reg == ST_READ) && (rd_k_reg == 3'd0);
        if (state_reg == ST_FIN && out_free)
        begin
            if (!inside_reg)
            begin
                vel_u_reg    <= '0;
                vel_v_reg    <= '0;
                in_grid_reg  <= 1'b0;
                smoothed_reg <= 1'b0;
            end
            else if (smooth_reg)
            begin
                vel_u_reg    <= avg_u;
                vel_v_reg    <= avg_v;
                in_grid_reg  <= 1'b1;
                smoothed_reg <= 1'b1;
            end
            else
            begin
                vel_u_reg    <= ctr_u;
                vel_v_reg    <= ctr_v;
                in_grid_reg  <= 1'b1;
                smoothed_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.vel_u        = vel_u_reg;
    assign rsp.vel_v        = vel_v_reg;
    assign rsp.in_grid      = in_grid_reg;
    assign rsp.was_smoothed = smoothed_reg;

    // shared multiply-accumulate and coordinate check
    gvl_mac #(
        .IDX_W (IDX_W),
        .LIM_W (LIM_W)
    ) u_mac (
        .clk       (clk),
        .ctrl      (mac_ctrl),
        .lim       (mac_lim),
        .prod      (mac_prod),
        .coord_ok  (coord_ok),
        .coord_idx (coord_idx)
    );

    // cell store: u in the low half, v in the high half
    gvl_ram #(
        .WIDTH (2 * VEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(req.cell_index)),
        .wr_data ({req.write_v, req.write_u}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // five-point average accumulators
    gvl_smooth u_smooth (
        .clk      (clk),
        .data_vld (rd_vld_reg),
        .first    (rd_first_reg),
        .rd_data  (ram_rd_data),
        .ctr_u    (ctr_u),
        .ctr_v    (ctr_v),
        .avg_u    (avg_u),
        .avg_v    (avg_v)
    );

endmodule

// ===== hw/rtl/gvl_checker.sv =====
`include "assert_macros.svh"

module gvl_checker
    import gvl_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic [OP_W-1:0]          req_operation,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic signed [VEL_W-1:0]  rsp_vel_u,
    input logic signed [VEL_W-1:0]  rsp_vel_v,
    input logic                     rsp_in_grid,
    input logic                     rsp_was_smoothed
);

    // a stalled result beat holds
    `GVL_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vel_u) && $stable(rsp_vel_v) && $stable(rsp_in_grid) && $stable(rsp_was_smoothed))

    // a query keeps the request side closed while it runs
    `GVL_ASSERT_NXT(a_query_busy, clk, rst_n, req_valid && req_ready && (req_operation == OP_PLAIN || req_operation == OP_SMOOTH), !req_ready)

    // smoothing only happens inside the grid
    `GVL_ASSERT_IMP(a_smooth_inside, clk, rst_n, rsp_valid && rsp_was_smoothed, rsp_in_grid)

    // off the grid the answer is zero velocity
    `GVL_ASSERT_IMP(a_outside_zero, clk, rst_n, rsp_valid && !rsp_in_grid, rsp_vel_u == '0 && rsp_vel_v == '0)

endmodule

bind grid_velocity_lookup_smooth_core gvl_checker u_gvl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_operation    (req.operation),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_vel_u        (rsp.vel_u),
    .rsp_vel_v        (rsp.vel_v),
    .rsp_in_grid      (rsp.in_grid),
    .rsp_was_smoothed (rsp.was_smoothed)
);

// ===== tb/grid_velocity_lookup_smooth_core_test.sv =====
module grid_velocity_lookup_smooth_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gvl_pkg::*;

    // clocking and run limits
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 24;    // covers the longest query to answer, a smoothed lookup
    localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is declared hung
    localparam int HOLD_AT        = 120;   // result beat after which the receiver backs off
    localparam int HOLD_CYCLES    = 400;

    // grid geometry of the block under test
    localparam int MAX_DIM     = 64;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    // the one operation code the package leaves unnamed, ignored by the block
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // one request beat as the sender sees it
    typedef struct {
        logic [OP_W-1:0]          op;
        logic [CIDX_W-1:0]        cidx;
        logic signed [VEL_W-1:0]  u;
        logic signed [VEL_W-1:0]  v;
        logic signed [LONG_W-1:0] plong;
        logic signed [LAT_W-1:0]  plat;
    } query_beat_t;

    // one answer beat
    typedef struct {
        logic signed [VEL_W-1:0] vel_u;
        logic signed [VEL_W-1:0] vel_v;
        logic                    in_grid;
        logic                    was_smoothed;
    } velocity_answer_t;

    // register image of the grid mapping
    typedef struct {
        logic [DIM_W-1:0]          rows;
        logic [DIM_W-1:0]          cols;
        logic signed [SCALE_W-1:0] xs;
        logic signed [OFFS_W-1:0]  xo;
        logic signed [SCALE_W-1:0] ys;
        logic signed [OFFS_W-1:0]  yo;
    } grid_setup_t;

    logic clk = 1'b0;
    logic rst_n;

    gvl_req_if req ();
    gvl_rsp_if rsp ();
    gvl_cfg_if cfg ();

    grid_velocity_lookup_smooth_core #(
        .MAX_ROWS (MAX_DIM),
        .MAX_COLS (MAX_DIM)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // predictor state: what the block holds, updated on accepted beats only
    grid_setup_t             grid_now = '{default: '0};
    logic signed [VEL_W-1:0] store_u [0:STORE_DEPTH-1];
    logic signed [VEL_W-1:0] store_v [0:STORE_DEPTH-1];

    // stimulus planning state: mapping as programmed, cells already given a write
    grid_setup_t grid_planned = '{default: '0};
    bit          cell_filled [0:STORE_DEPTH-1];

    query_beat_t      pending_beats [$];
    velocity_answer_t expected_answers [$];
    query_beat_t      req_cur;

    int          fail_count   = 0;
    int          beats_sent   = 0;
    int          answers_seen = 0;
    int          quiet_cycles = 0;
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;
    bit          send_calm    = 1'b0;
    bit          recv_calm    = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // exact p*scale+offs with 40 fraction bits, truncated toward zero,
    // then tested against [0, limit)
    function automatic bit axis_index(input logic signed [ACC_W-1:0] p,
                                      input logic signed [SCALE_W-1:0] scale,
                                      input logic signed [OFFS_W-1:0] offs,
                                      input int unsigned limit,
                                      output int unsigned idx);
        logic signed [ACC_W-1:0] wide_scale;
        logic signed [ACC_W-1:0] wide_offs;
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-1:0]        whole;
        wide_scale = ACC_W'(scale);
        wide_offs  = ACC_W'(offs);
        acc   = p * wide_scale + wide_offs;
        whole = (acc < 0) ? ((-acc) >> FRAC_W) : (acc >> FRAC_W);
        idx   = whole[31:0];
        // anything in (-1,0) truncates to column or row zero
        if (acc < 0 && whole != 0)
            return 1'b0;
        return whole < limit;
    endfunction

    // cell hit by a point; rows and columns above the store size are clamped
    function automatic bit locate(input grid_setup_t s,
                                  input logic signed [LONG_W-1:0] lg,
                                  input logic signed [LAT_W-1:0] lt,
                                  output int unsigned col, output int unsigned row,
                                  output int unsigned rows, output int unsigned cols);
        rows = (s.rows > MAX_DIM) ? MAX_DIM : s.rows;
        cols = (s.cols > MAX_DIM) ? MAX_DIM : s.cols;
        col  = 0;
        row  = 0;
        return axis_index(ACC_W'(lg), s.xs, s.xo, cols, col) &&
               axis_index(ACC_W'(lt), s.ys, s.yo, rows, row);
    endfunction

    // (4*mid + neighbours)/8, round half up, clamp to 32 bits
    function automatic logic signed [VEL_W-1:0] blend(input logic signed [VEL_W-1:0] mid,
                                                      input logic signed [VEL_W-1:0] n0,
                                                      input logic signed [VEL_W-1:0] n1,
                                                      input logic signed [VEL_W-1:0] n2,
                                                      input logic signed [VEL_W-1:0] n3);
        logic signed [63:0] t;
        t = 4 * mid + n0 + n1 + n2 + n3 + 4;
        t = t >>> 3;
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        else if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t[VEL_W-1:0];
    endfunction

    function automatic velocity_answer_t predict_answer(input query_beat_t b);
        velocity_answer_t a;
        int unsigned      col, row, rows, cols, base;
        a = '{default: '0};
        if (locate(grid_now, b.plong, b.plat, col, row, rows, cols))
        begin
            base      = row * cols + col;
            a.in_grid = 1'b1;
            a.vel_u   = store_u[base];
            a.vel_v   = store_v[base];
            // only interior cells get the neighbour average
            if (b.op == OP_SMOOTH && col > 0 && col + 1 < cols && row > 0 && row + 1 < rows)
            begin
                a.vel_u = blend(store_u[base], store_u[base + cols], store_u[base - cols],
                                store_u[base - 1], store_u[base + 1]);
                a.vel_v = blend(store_v[base], store_v[base + cols], store_v[base - cols],
                                store_v[base - 1], store_v[base + 1]);
                a.was_smoothed = 1'b1;
            end
        end
        return a;
    endfunction

    function automatic grid_setup_t with_reg(input grid_setup_t s,
                                             input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DAT_W-1:0] d);
        case (idx)
            REG_NUM_ROWS: s.rows = d[DIM_W-1:0];
            REG_NUM_COLS: s.cols = d[DIM_W-1:0];
            REG_X_SCALE:  s.xs   = d[SCALE_W-1:0];
            REG_X_OFFSET: s.xo   = d;
            REG_Y_SCALE:  s.ys   = d[SCALE_W-1:0];
            REG_Y_OFFSET: s.yo   = d;
            default: ;
        endcase
        return s;
    endfunction

    // predictor update for one accepted request beat
    task automatic note_accept(input query_beat_t b);
        case (b.op)
            OP_WRITE:
            begin
                store_u[b.cidx] = b.u;
                store_v[b.cidx] = b.v;
            end
            OP_PLAIN, OP_SMOOTH: expected_answers.push_back(predict_answer(b));
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned pause_len(input bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic int any_long();
        int v;
        v = $urandom_range(0, 360000000);
        return v - 180000000;
    endfunction

    function automatic int any_lat();
        int v;
        v = $urandom_range(0, 180000000);
        return v - 90000000;
    endfunction

    // point near the start of a unit cell of the directed 2^20 microdegree mapping
    function automatic int unit_point(input int n);
        return (n <<< 20) + 1000;
    endfunction

    // unused payload fields still carry random bits
    function automatic query_beat_t blank_beat(input logic [OP_W-1:0] op);
        query_beat_t b;
        b.op    = op;
        b.cidx  = CIDX_W'($urandom);
        b.u     = $urandom;
        b.v     = $urandom;
        b.plong = LONG_W'(any_long());
        b.plat  = LAT_W'(any_lat());
        return b;
    endfunction

    // mapping that spreads the full long/lat range a little past the grid edges
    function automatic grid_setup_t fitted_grid(input int unsigned rows, input int unsigned cols,
                                                input bit flip_x, input bit flip_y);
        grid_setup_t s;
        longint      ex, ey, sx, sy;
        ex = 64'((cols > MAX_DIM) ? MAX_DIM : cols);
        ey = 64'((rows > MAX_DIM) ? MAX_DIM : rows);
        sx = ((ex + 2) <<< FRAC_W) / 64'sd360000000;
        sy = ((ey + 2) <<< FRAC_W) / 64'sd180000000;
        s.rows = DIM_W'(rows);
        s.cols = DIM_W'(cols);
        s.xs   = SCALE_W'(flip_x ? -sx : sx);
        s.ys   = SCALE_W'(flip_y ? -sy : sy);
        s.xo   = (ex <<< (FRAC_W - 1)) + $urandom_range(0, 1 << 20);
        s.yo   = (ey <<< (FRAC_W - 1)) + $urandom;
        return s;
    endfunction

    task automatic queue_write(input int unsigned idx, input logic signed [VEL_W-1:0] u,
                               input logic signed [VEL_W-1:0] v);
        query_beat_t b;
        b      = blank_beat(OP_WRITE);
        b.cidx = CIDX_W'(idx);
        b.u    = u;
        b.v    = v;
        pending_beats.push_back(b);
        cell_filled[idx] = 1'b1;
    endtask

    task automatic fill_cell(input int unsigned idx);
        if (!cell_filled[idx])
            queue_write(idx, $urandom, $urandom);
    endtask

    // a lookup never reaches a cell that was not written: missing cells get a write first
    task automatic queue_lookup(input logic [OP_W-1:0] op, input int lg, input int lt);
        query_beat_t b;
        int unsigned col, row, rows, cols, base;
        if (locate(grid_planned, LONG_W'(lg), LAT_W'(lt), col, row, rows, cols))
        begin
            base = row * cols + col;
            fill_cell(base);
            if (op == OP_SMOOTH && col > 0 && col + 1 < cols && row > 0 && row + 1 < rows)
            begin
                fill_cell(base - 1);
                fill_cell(base + 1);
                fill_cell(base - cols);
                fill_cell(base + cols);
            end
        end
        b       = blank_beat(op);
        b.plong = LONG_W'(lg);
        b.plat  = LAT_W'(lt);
        pending_beats.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        grid_planned = with_reg(grid_planned, idx, d);
    endtask

    // nothing queued, nothing offered, nothing owed, then let the pipeline settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || req.valid || expected_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic begin_phase(input grid_setup_t s);
        wait_drained();
        write_reg(REG_NUM_ROWS, 64'(s.rows));
        write_reg(REG_NUM_COLS, 64'(s.cols));
        write_reg(REG_X_SCALE,  64'(s.xs));
        write_reg(REG_X_OFFSET, s.xo);
        write_reg(REG_Y_SCALE,  64'(s.ys));
        write_reg(REG_Y_OFFSET, s.yo);
    endtask

    // random mix: mostly lookups, some stray writes, a few ignored beats
    task automatic run_phase(input grid_setup_t s, input int unsigned actions);
        int unsigned k;
        begin_phase(s);
        repeat (actions)
        begin
            k = $urandom_range(0, 99);
            if (k < 10)
                queue_write($urandom_range(0, STORE_DEPTH - 1), $urandom, $urandom);
            else if (k < 13)
                pending_beats.push_back(blank_beat(OP_SPARE));
            else
                queue_lookup((k < 45) ? OP_PLAIN : OP_SMOOTH, any_long(), any_lat());
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: one beat at a time from the pending queue
    // ------------------------------------------------------------------

    task automatic present(input query_beat_t b);
        req_cur        <= b;
        req.valid      <= 1'b1;
        req.operation  <= b.op;
        req.cell_index <= b.cidx;
        req.write_u    <= b.u;
        req.write_v    <= b.v;
        req.point_long <= b.plong;
        req.point_lat  <= b.plat;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned gap;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            send_wait <= 0;
        end
        else if (req.valid && req.ready)
        begin
            // beat taken: predict, then either keep valid high or back off
            note_accept(req_cur);
            beats_sent++;
            if (beats_sent % 40 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            gap = pause_len(send_calm);
            if (gap == 0 && pending_beats.size() != 0)
                present(pending_beats.pop_front());
            else
            begin
                req.valid <= 1'b0;
                send_wait <= gap;
            end
        end
        else if (!req.valid)
        begin
            if (send_wait != 0)
                send_wait <= send_wait - 1;
            else if (pending_beats.size() != 0)
                present(pending_beats.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each beat against the oldest expectation
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned      gap;
        velocity_answer_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (rsp.valid && rsp.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result beat with no query outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                check_field("vel_u", 64'(want.vel_u), 64'(rsp.vel_u));
                check_field("vel_v", 64'(want.vel_v), 64'(rsp.vel_v));
                check_field("in_grid", 64'(want.in_grid), 64'(rsp.in_grid));
                check_field("was_smoothed", 64'(want.was_smoothed), 64'(rsp.was_smoothed));
            end
            answers_seen++;
            if (answers_seen % 50 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            // one long back-off so the block holds its answer and stalls the sender
            gap = (answers_seen == HOLD_AT) ? HOLD_CYCLES : pause_len(recv_calm);
            rsp.ready <= (gap == 0);
            recv_wait <= gap;
        end
        else if (!rsp.ready)
        begin
            if (recv_wait != 0)
                recv_wait <= recv_wait - 1;
            else
                rsp.ready <= 1'b1;
        end
    end

    // predictor copy of the registers follows accepted config beats
    always @(posedge clk)
    begin
        if (rst_n && cfg.valid && cfg.ready)
            grid_now = with_reg(grid_now, cfg.index, cfg.data);
    end

    // watchdog: any accepted beat on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("grid_velocity_lookup_smooth_core_test NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------

    initial
    begin
        grid_setup_t unit_grid;
        int          i;
        logic signed [VEL_W-1:0] u, v;

        // every input known from time zero
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.operation  = OP_WRITE;
        req.cell_index = '0;
        req.write_u    = '0;
        req.write_v    = '0;
        req.point_long = '0;
        req.point_lat  = '0;
        rsp.ready      = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_NUM_ROWS;
        cfg.data       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers at reset value: no grid, every lookup misses
        queue_lookup(OP_PLAIN, any_long(), any_lat());
        queue_lookup(OP_SMOOTH, any_long(), any_lat());

        // directed: 3x3 grid, one cell per 2^20 microdegrees, origin at zero
        unit_grid = '{rows: 7'd3, cols: 7'd3, xs: 48'sd1048576, xo: 64'sd0,
                      ys: 48'sd1048576, yo: 64'sd0};
        begin_phase(unit_grid);
        for (i = 0; i < 9; i++)
        begin
            if (i == 4)
            begin
                u = 32'sh8000_0000;
                v = 32'sh7fff_ffff;
            end
            else if (i % 2 == 1)
            begin
                u = 32'sh7fff_ffff;
                v = 32'sh8000_0000;
            end
            else
            begin
                u = $urandom;
                v = $urandom;
            end
            queue_write(i, u, v);
        end
        queue_lookup(OP_PLAIN,  unit_point(1), unit_point(1));
        queue_lookup(OP_SMOOTH, unit_point(1), unit_point(1));   // interior, ties at extremes
        queue_lookup(OP_SMOOTH, unit_point(0), unit_point(1));   // edge cell, no average
        queue_lookup(OP_SMOOTH, unit_point(2), unit_point(2));   // corner cell
        queue_lookup(OP_PLAIN,  -1, -1);                         // (-1,0) truncates into cell 0
        queue_lookup(OP_SMOOTH, -1, unit_point(1));
        queue_lookup(OP_PLAIN,  -(1 <<< 20), unit_point(1));     // exactly -1: off the grid
        queue_lookup(OP_PLAIN,  unit_point(1), 3 <<< 20);        // one past the last row
        pending_beats.push_back(blank_beat(OP_SPARE));
        queue_lookup(OP_PLAIN,  180000000, 90000000);
        queue_lookup(OP_SMOOTH, -180000000, -90000000);
        // half-way cases round toward plus infinity for both signs
        queue_write(4, 32'sd0, -32'sd1);
        queue_lookup(OP_SMOOTH, unit_point(1), unit_point(1));

        // random phases over several grid shapes and mappings
        run_phase(fitted_grid(8, 8, 1'b0, 1'b0), 200);
        run_phase(fitted_grid(64, 64, 1'b0, 1'b0), 60);
        run_phase(fitted_grid(1, 64, 1'b0, 1'b0), 80);
        run_phase(fitted_grid(127, 100, 1'b0, 1'b1), 30);        // clamped to the store size
        run_phase(fitted_grid(5, 7, 1'b1, 1'b1), 150);
        run_phase(fitted_grid(0, 16, 1'b0, 1'b0), 40);           // no grid at all
        run_phase('{rows: 7'd64, cols: 7'd64,
                    xs: 48'sh8000_0000_0000, xo: 64'sh7fff_ffff_ffff_ffff,
                    ys: 48'sh7fff_ffff_ffff, yo: 64'sh8000_0000_0000_0000}, 40);
        // zero scale pins every point to one interior cell
        run_phase('{rows: 7'd4, cols: 7'd4, xs: 48'sd0, xo: (64'sd1 <<< FRAC_W) + 64'sd12345,
                    ys: 48'sd0, yo: (64'sd2 <<< FRAC_W) + 64'sd999}, 40);
        run_phase(fitted_grid(16, 16, 1'b0, 1'b0), 100);

        wait_drained();
        if (fail_count == 0 && expected_answers.size() == 0)
            $display("grid_velocity_lookup_smooth_core_test OK");
        else
            $display("grid_velocity_lookup_smooth_core_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gvl_pkg.sv
hw/rtl/gvl_if.sv
hw/rtl/gvl_ram.sv
hw/rtl/gvl_mac.sv
hw/rtl/gvl_smooth.sv
hw/rtl/grid_velocity_lookup_smooth_core.sv
hw/rtl/gvl_checker.sv
tb/grid_velocity_lookup_smooth_core_test.sv
